// ----- src/dat_pkg.sv -----
// Shared constants, node entry layout and result codes for the trie prefix matcher.
// No dependencies; compiled first.
package dat_pkg;

    // Table size limit and length counter width
    localparam int MAX_NODES   = 4096;
    localparam int LENGTH_BITS = 16;

    // Field widths fixed by the item layout
    localparam int NODE_AW  = 12;
    localparam int LABEL_W  = 8;
    localparam int VALUE_W  = 31;
    localparam int COUNT_W  = 13;
    localparam int LEN_W    = 16;
    localparam int KIND_W   = 2;
    localparam int CFG_IW   = 1;
    localparam int CFG_DW   = 13;
    localparam int RAM_DEPTH = 2 ** NODE_AW;

    // Saturation point of the byte counter
    localparam int LEN_USED = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'((64'd1 << LEN_USED) - 64'd1);

    // Cap applied to node_count when forming the walk bound
    localparam logic [COUNT_W-1:0] NODE_LIMIT =
        COUNT_W'((MAX_NODES < (2 ** COUNT_W)) ? MAX_NODES : (2 ** COUNT_W) - 1);

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_NODE_COUNT  = 1'd0;
    localparam logic [CFG_IW-1:0] REG_REPORT_MODE = 1'd1;

    // Input actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // One table entry
    typedef struct packed {
        logic [NODE_AW-1:0] offset;
        logic [LABEL_W-1:0] label;
        logic               leaf;
        logic [VALUE_W-1:0] value;
    } node_t;

endpackage

// ----- src/dat_stream_if.sv -----
// Valid/ready channel interfaces for input items and result beats.
// Depends on dat_pkg for field widths.
interface dat_item_if;
    import dat_pkg::*;

    logic               valid;
    logic               ready;
    logic               action;
    logic [NODE_AW-1:0] node_index;
    logic [NODE_AW-1:0] node_offset;
    logic [LABEL_W-1:0] node_label;
    logic               node_leaf;
    logic [VALUE_W-1:0] node_value;
    logic [LABEL_W-1:0] query_byte;
    logic               query_last;

    modport source (
        output valid, action, node_index, node_offset, node_label, node_leaf,
               node_value, query_byte, query_last,
        input  ready
    );
    modport sink (
        input  valid, action, node_index, node_offset, node_label, node_leaf,
               node_value, query_byte, query_last,
        output ready
    );
endinterface

interface dat_result_if;
    import dat_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic [VALUE_W-1:0] match_id;
    logic [LEN_W-1:0]   prefix_len;
    logic               result_last;

    modport source (
        output valid, result_kind, match_id, prefix_len, result_last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, match_id, prefix_len, result_last,
        output ready
    );
endinterface

// ----- src/double_array_trie_prefix_match_core.sv -----
// Double-array trie prefix matcher: node table loading, byte walk, result output.
// Query byte steps: accept, then root, node and value reads through the node RAM read port,
// then the end beat on the last byte.
// Throughput: one item at a time; a full output register stalls the walk and the input.
// Reset: async active low clears walk state, registers and output valid; table is not cleared.
// Depends on dat_pkg, dat_stream_if and dat_node_ram.
module double_array_trie_prefix_match_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dat_pkg::CFG_IW-1:0]    cfg_index,
    input  logic [dat_pkg::CFG_DW-1:0]    cfg_data,
    dat_item_if.sink                      item,
    dat_result_if.source                  result
);
    import dat_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ROOT, S_NODE, S_VALUE, S_END} state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    logic               mode_reg, mode_next;
    logic [NODE_AW-1:0] position_reg, position_next;
    logic [NODE_AW-1:0] cur_reg, cur_next;
    logic               at_start_reg, at_start_next;
    logic               stopped_reg, stopped_next;
    logic               error_reg, error_next;
    logic [LEN_W-1:0]   byte_count_reg, byte_count_next;
    logic [VALUE_W-1:0] best_id_reg, best_id_next;
    logic [LEN_W-1:0]   best_len_reg, best_len_next;
    logic [LABEL_W-1:0] byte_reg, byte_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [VALUE_W-1:0] out_id_reg, out_id_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               out_free;
    logic [COUNT_W-1:0] lim;
    logic [NODE_AW-1:0] base_pos;
    logic [LABEL_W-1:0] step_byte;
    logic [NODE_AW-1:0] p1;
    logic               p1_ok;
    logic [NODE_AW-1:0] p2;
    logic               p2_ok;
    logic               label_ok;
    logic [LEN_W-1:0]   cnt_base;
    logic               stop_base;
    state_t             fin_state;

    logic               ram_we;
    logic               ram_re;
    logic [NODE_AW-1:0] ram_raddr;
    node_t              ram_wdata;
    node_t              ram_rdata;

    dat_node_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (item.node_index),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and output register drive
    assign item.ready          = (state_reg == S_IDLE);
    assign accept              = item.valid && item.ready;
    assign out_free            = !out_valid_reg || result.ready;
    assign result.valid        = out_valid_reg;
    assign result.result_kind  = out_kind_reg;
    assign result.match_id     = out_id_reg;
    assign result.prefix_len   = out_len_reg;
    assign result.result_last  = out_last_reg;

    // Node write path
    assign ram_wdata.offset = item.node_offset;
    assign ram_wdata.label  = item.node_label;
    assign ram_wdata.leaf   = item.node_leaf;
    assign ram_wdata.value  = item.node_value;
    assign ram_we = accept && (item.action == ACT_WRITE)
                    && (32'(item.node_index) < MAX_NODES);

    // Walk bound and step arithmetic
    assign lim       = (node_count_reg < NODE_LIMIT) ? node_count_reg : NODE_LIMIT;
    assign base_pos  = (state_reg == S_ROOT) ? ram_rdata.offset : position_reg;
    assign step_byte = (state_reg == S_IDLE) ? item.query_byte : byte_reg;
    assign p1        = base_pos ^ NODE_AW'(step_byte);
    assign p1_ok     = {1'b0, p1} < lim;
    assign label_ok  = (ram_rdata.label == byte_reg);
    assign p2        = cur_reg ^ ram_rdata.offset;
    assign p2_ok     = {1'b0, p2} < lim;
    assign cnt_base  = at_start_reg ? '0 : byte_count_reg;
    assign stop_base = at_start_reg ? (lim == '0) : stopped_reg;
    assign fin_state = ((state_reg == S_IDLE) ? item.query_last : last_reg) ? S_END : S_IDLE;

    // Next-state logic for the walk
    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        mode_next       = mode_reg;
        position_next   = position_reg;
        cur_next        = cur_reg;
        at_start_next   = at_start_reg;
        stopped_next    = stopped_reg;
        error_next      = error_reg;
        byte_count_next = byte_count_reg;
        best_id_next    = best_id_reg;
        best_len_next   = best_len_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_kind_next   = out_kind_reg;
        out_id_next     = out_id_reg;
        out_len_next    = out_len_reg;
        out_last_next   = out_last_reg;
        ram_re          = 1'b0;
        ram_raddr       = p1;

        // Configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NODE_COUNT:  node_count_next = cfg_data;
                REG_REPORT_MODE: mode_next       = cfg_data[0];
                default:         mode_next       = mode_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.action == ACT_QUERY))
                begin
                    byte_next       = item.query_byte;
                    last_next       = item.query_last;
                    at_start_next   = 1'b0;
                    byte_count_next = (cnt_base < LEN_MAX) ? cnt_base + 1'b1 : cnt_base;
                    stopped_next    = stop_base;
                    if (at_start_reg)
                    begin
                        error_next    = 1'b0;
                        best_id_next  = '0;
                        best_len_next = '0;
                    end
                    // Skip the walk when stopped or on a zero byte
                    priority if (stop_base || (item.query_byte == '0))
                    begin
                        stopped_next = 1'b1;
                        state_next   = fin_state;
                    end
                    else if (at_start_reg)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = S_ROOT;
                    end
                    else if (!p1_ok)
                    begin
                        stopped_next = 1'b1;
                        state_next   = fin_state;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        cur_next   = p1;
                        state_next = S_NODE;
                    end
                end
            end
            S_ROOT:
            begin
                position_next = ram_rdata.offset;
                if (p1_ok)
                begin
                    ram_re     = 1'b1;
                    cur_next   = p1;
                    state_next = S_NODE;
                end
                else
                begin
                    stopped_next = 1'b1;
                    state_next   = fin_state;
                end
            end
            S_NODE:
            begin
                priority if (!label_ok)
                begin
                    stopped_next = 1'b1;
                    state_next   = fin_state;
                end
                else if (!p2_ok)
                begin
                    stopped_next = 1'b1;
                    error_next   = 1'b1;
                    state_next   = fin_state;
                end
                else
                begin
                    position_next = p2;
                    if (ram_rdata.leaf)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = p2;
                        state_next = S_VALUE;
                    end
                    else
                    begin
                        state_next = fin_state;
                    end
                end
            end
            S_VALUE:
            begin
                // Keep the best match, or hand the match to the output register
                if (mode_reg)
                begin
                    best_id_next  = ram_rdata.value;
                    best_len_next = byte_count_reg;
                    state_next    = fin_state;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_MATCH;
                    out_id_next    = ram_rdata.value;
                    out_len_next   = byte_count_reg;
                    out_last_next  = 1'b0;
                    state_next     = fin_state;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = error_reg ? KIND_ERROR : KIND_OK;
                    out_id_next    = mode_reg ? best_id_reg : '0;
                    out_len_next   = mode_reg ? best_len_reg : '0;
                    out_last_next  = 1'b1;
                    at_start_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= '0;
            mode_reg       <= 1'b0;
            position_reg   <= '0;
            cur_reg        <= '0;
            at_start_reg   <= 1'b1;
            stopped_reg    <= 1'b0;
            error_reg      <= 1'b0;
            byte_count_reg <= '0;
            best_id_reg    <= '0;
            best_len_reg   <= '0;
            byte_reg       <= '0;
            last_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_MATCH;
            out_id_reg     <= '0;
            out_len_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            mode_reg       <= mode_next;
            position_reg   <= position_next;
            cur_reg        <= cur_next;
            at_start_reg   <= at_start_next;
            stopped_reg    <= stopped_next;
            error_reg      <= error_next;
            byte_count_reg <= byte_count_next;
            best_id_reg    <= best_id_next;
            best_len_reg   <= best_len_next;
            byte_reg       <= byte_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_id_reg     <= out_id_next;
            out_len_reg    <= out_len_next;
            out_last_reg   <= out_last_next;
        end
    end

`ifndef SYNTHESIS
    // Node RAM: never read and write in one cycle
    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("node RAM read and write collide");

    // After a node write the core is back in idle on the next cycle
    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.action == ACT_WRITE) |=> state_reg == S_IDLE)
        else $error("node write did not return to idle");

    // A beat that is not the last one is always a match
    a_mid_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_last_reg |-> out_kind_reg == KIND_MATCH)
        else $error("non-final result with end kind");

    // End beat carries a finishing kind
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> (out_kind_reg == KIND_OK || out_kind_reg == KIND_ERROR))
        else $error("end result with match kind");
`endif
endmodule

// ----- src/dat_node_ram.sv -----
// Node table with separate write and read ports, registered read data.
// Depends on dat_pkg for the entry layout and depth.
module dat_node_ram (
    input  logic                   clk,
    input  logic                   we,
    input  logic [dat_pkg::NODE_AW-1:0] waddr,
    input  dat_pkg::node_t         wdata,
    input  logic                   re,
    input  logic [dat_pkg::NODE_AW-1:0] raddr,
    output dat_pkg::node_t         rdata
);
    import dat_pkg::*;

    node_t mem [RAM_DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
